// File: src/length_prefixed_frame_deframer_assert.svh
// Assertion macros shared by the deframer modules.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS
`define LPFD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("deframer assertion failed");
`define LPFD_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("deframer forbidden condition seen");
`else
`define LPFD_ASSERT(lbl, clk, rst, prop)
`define LPFD_ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

// File: src/lpfd_pkg.sv
package lpfd_pkg;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic ERR_TOO_SHORT = 1'b0;
  localparam logic ERR_TOO_LARGE = 1'b1;

  localparam logic [31:0] HEADER_BYTES    = 32'd8;
  localparam logic [31:0] MAX_FRAME_RESET = 32'd1048576;

  localparam logic [2:0] LENGTH_LAST_INDEX = 3'd3;
  localparam logic [2:0] HEADER_LAST_INDEX = 3'd7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] api_key;
    logic [15:0] key_version;
    logic [31:0] request_tag;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        frame_last;
    logic        error_code;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } front_req_t;

endpackage

// File: src/lpfd_front.sv
`include "length_prefixed_frame_deframer_assert.svh"

module lpfd_front
  import lpfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  data_byte,
  input  logic        cfg_write_en,
  input  logic [31:0] cfg_write_data,
  output front_req_t  req
);

  localparam logic [1:0] PH_LENGTH  = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_ERROR   = 2'd3;

  logic [1:0]  phase;
  logic [1:0]  phase_next;
  logic [2:0]  byte_index;
  logic [2:0]  byte_index_next;
  logic [31:0] remaining;
  logic [31:0] remaining_next;
  logic [31:0] length_bytes;
  logic [63:0] header_bytes;
  logic [31:0] max_frame_length;
  logic        accept;
  logic [31:0] length_full;
  logic [63:0] header_full;

  assign accept      = push && !full;
  assign length_full = {data_byte, length_bytes[23:0]};
  assign header_full = {data_byte, header_bytes[55:0]};

  always_comb begin
    phase_next      = phase;
    byte_index_next = byte_index;
    remaining_next  = remaining;
    req             = '0;
    case (phase)
      PH_LENGTH: begin
        if (accept) begin
          if (byte_index == LENGTH_LAST_INDEX) begin
            byte_index_next = '0;
            if (length_full < HEADER_BYTES) begin
              req.valid          = 1'b1;
              req.res.kind       = KIND_ERROR;
              req.res.error_code = ERR_TOO_SHORT;
              phase_next         = PH_ERROR;
            end else if (length_full > max_frame_length) begin
              req.valid          = 1'b1;
              req.res.kind       = KIND_ERROR;
              req.res.error_code = ERR_TOO_LARGE;
              phase_next         = PH_ERROR;
            end else begin
              remaining_next = length_full - HEADER_BYTES;
              phase_next     = PH_HEADER;
            end
          end else begin
            byte_index_next = byte_index + 3'd1;
          end
        end
      end
      PH_HEADER: begin
        if (accept) begin
          if (byte_index == HEADER_LAST_INDEX) begin
            byte_index_next            = '0;
            req.valid                  = 1'b1;
            req.res.kind               = KIND_HEADER;
            req.res.api_key            = header_full[15:0];
            req.res.key_version        = header_full[31:16];
            req.res.request_tag        = header_full[63:32];
            req.res.payload_length     = remaining;
            req.res.frame_last         = (remaining == '0);
            phase_next                 = (remaining == '0) ? PH_LENGTH : PH_PAYLOAD;
          end else begin
            byte_index_next = byte_index + 3'd1;
          end
        end
      end
      PH_PAYLOAD: begin
        if (accept) begin
          req.valid            = 1'b1;
          req.res.kind         = KIND_PAYLOAD;
          req.res.payload_byte = data_byte;
          remaining_next       = remaining - 32'd1;
          if (remaining == 32'd1) begin
            req.res.frame_last = 1'b1;
            phase_next         = PH_LENGTH;
            byte_index_next    = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_LENGTH;
      byte_index       <= '0;
      max_frame_length <= MAX_FRAME_RESET;
    end else begin
      phase      <= phase_next;
      byte_index <= byte_index_next;
      if (cfg_write_en) begin
        max_frame_length <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    remaining <= remaining_next;
    if (accept && phase == PH_LENGTH) begin
      length_bytes[byte_index[1:0]*8 +: 8] <= data_byte;
    end
    if (accept && phase == PH_HEADER) begin
      header_bytes[byte_index*8 +: 8] <= data_byte;
    end
  end

  // Once an error is seen the parser never leaves the error phase.
  `LPFD_ASSERT(a_error_sticks, clk, rst, phase == PH_ERROR |=> phase == PH_ERROR)
  // Errors come only from the last length byte.
  `LPFD_ASSERT(a_error_on_length, clk, rst,
    req.valid && req.res.kind == KIND_ERROR |->
      phase == PH_LENGTH && byte_index == LENGTH_LAST_INDEX)

endmodule

// File: src/lpfd_queue.sv
`include "length_prefixed_frame_deframer_assert.svh"

module lpfd_queue
  import lpfd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  front_req_t req,
  input  logic       read,
  output logic       full,
  output logic       empty,
  output result_t    head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  result_t          slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_write;
  logic             do_read;

  assign full     = (count == FULL_COUNT);
  assign empty    = (count == '0);
  assign do_write = req.valid;
  assign do_read  = read && !empty;
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_write) begin
      slots[wr_ptr] <= req.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_write) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_read) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_write && !do_read) begin
        count <= count + CNT_W'(1);
      end else if (do_read && !do_write) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `LPFD_ASSERT_NEVER(a_no_overflow, clk, rst, count > FULL_COUNT)
  `LPFD_ASSERT_NEVER(a_no_write_when_full, clk, rst, do_write && full)

endmodule

// File: src/lpfd_back.sv
module lpfd_back
  import lpfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  result_t q_head,
  output logic    q_read,
  input  logic    pop,
  output logic    empty,
  output result_t res
);

  logic    out_valid;
  result_t out_res;

  assign q_read = !q_empty && (!out_valid || pop);
  assign empty  = !out_valid;
  assign res    = out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_read) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_read) begin
      out_res <= q_head;
    end
  end

endmodule

// File: src/length_prefixed_frame_deframer.sv
// Length-prefixed frame deframer.
// Input channel: data_byte is offered with push and taken when full is low.
// Each frame is a 4-byte little-endian length, an 8-byte header (key, version,
// request tag) and length - 8 payload bytes.
// Result channel: while empty is low the oldest result sits on the result
// ports; pop takes it. kind tells a header, a payload byte or an error apart.
// One byte is taken every cycle while the queue has room. A result is written
// into the queue by the edge that takes its byte, then moves into the output
// register once that register is empty or being popped.
// cfg_write_en with cfg_write_data sets the largest accepted length; it
// applies to the next length check.
// Reset empties the queue and output register, restarts length gathering,
// clears a past error and sets the maximum to 1048576.
// When the receiver stops popping, results pile up in the queue of
// QUEUE_DEPTH entries plus the output register; full then rises and input
// stops until a pop frees a slot. After an error the block drops all bytes.
module length_prefixed_frame_deframer
  import lpfd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        cfg_write_en,
  input  logic [31:0] cfg_write_data,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [15:0] api_key,
  output logic [15:0] key_version,
  output logic [31:0] request_tag,
  output logic [31:0] payload_length,
  output logic [7:0]  payload_byte,
  output logic        frame_last,
  output logic        error_code
);

  front_req_t req;
  logic       q_full;
  logic       q_empty;
  logic       q_read;
  result_t    q_head;
  result_t    res;

  assign full = q_full;

  lpfd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (q_full),
    .data_byte      (data_byte),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .req            (req)
  );

  lpfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .read  (q_read),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  lpfd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_read  (q_read),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign kind           = res.kind;
  assign api_key        = res.api_key;
  assign key_version    = res.key_version;
  assign request_tag    = res.request_tag;
  assign payload_length = res.payload_length;
  assign payload_byte   = res.payload_byte;
  assign frame_last     = res.frame_last;
  assign error_code     = res.error_code;

endmodule
